### rtl/assert_macros.svh
// Assertion macros shared by the decoder modules.
// Each macro expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PCD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("percent decoder assertion failed");

// Same check with a caller-supplied message.
`define PCD_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

### rtl/pcd_pkg.sv
package pcd_pkg;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic REG_PLUS_AS_SPACE = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // Up to three decoded bytes produced by one input item
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            last;
    } t_entry;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } t_hex;

    // Classify one character as a hex digit of either case
    function automatic t_hex hex_value(logic [7:0] c);
        t_hex h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.valid = 1'b1;
            h.val   = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.valid = 1'b1;
            h.val   = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.valid = 1'b1;
            h.val   = 4'(c - 8'h61 + 8'd10);
        end
        return h;
    endfunction

    // Add one byte at the next free slot of an entry
    function automatic t_entry append(t_entry e, logic [7:0] b);
        t_entry r;
        r = e;
        case (e.cnt)
            2'd0:    r.bytes[0] = b;
            2'd1:    r.bytes[1] = b;
            2'd2:    r.bytes[2] = b;
            default: r.bytes[2] = e.bytes[2];
        endcase
        r.cnt = e.cnt + 2'd1;
        return r;
    endfunction

endpackage

### rtl/pcd_front.sv
`include "assert_macros.svh"

module pcd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pcd_pkg::t_in     i_data,
    input  logic             i_plus_as_space,
    input  logic             i_q_full,
    output logic             o_stall,
    output logic             o_push,
    output pcd_pkg::t_entry  o_entry
);

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    logic [1:0]      r_held_cnt;
    logic [1:0]      n_held_cnt;
    logic [7:0]      r_held_digit;
    logic [7:0]      n_held_digit;
    pcd_pkg::t_entry v_e;
    pcd_pkg::t_hex   v_h;
    pcd_pkg::t_hex   v_hh;
    logic            v_fresh;
    logic            accept;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    // Classify the byte against what is held and collect its output bytes
    always_comb begin
        v_e          = '0;
        v_e.last     = i_data.in_last;
        n_held_cnt   = r_held_cnt;
        n_held_digit = r_held_digit;
        v_fresh      = 1'b0;
        v_h          = pcd_pkg::hex_value(i_data.data_byte);
        v_hh         = pcd_pkg::hex_value(r_held_digit);

        case (r_held_cnt)
            HELD_PCT: begin
                if (v_h.valid) begin
                    n_held_digit = i_data.data_byte;
                    n_held_cnt   = HELD_DIGIT;
                end else begin
                    v_e        = pcd_pkg::append(v_e, pcd_pkg::CH_PCT);
                    n_held_cnt = HELD_NONE;
                    v_fresh    = 1'b1;
                end
            end
            HELD_DIGIT: begin
                n_held_cnt = HELD_NONE;
                if (v_h.valid) begin
                    v_e = pcd_pkg::append(v_e, {v_hh.val, v_h.val});
                end else begin
                    v_e     = pcd_pkg::append(v_e, pcd_pkg::CH_PCT);
                    v_e     = pcd_pkg::append(v_e, r_held_digit);
                    v_fresh = 1'b1;
                end
            end
            default: begin
                n_held_cnt = HELD_NONE;
                v_fresh    = 1'b1;
            end
        endcase

        // Handle the byte as if nothing were held
        if (v_fresh) begin
            if (i_data.data_byte == pcd_pkg::CH_PCT) begin
                n_held_cnt = HELD_PCT;
            end else if (i_data.data_byte == pcd_pkg::CH_PLUS && i_plus_as_space) begin
                v_e = pcd_pkg::append(v_e, pcd_pkg::CH_SPACE);
            end else begin
                v_e = pcd_pkg::append(v_e, i_data.data_byte);
            end
        end

        // Flush held bytes at the end of the string
        if (i_data.in_last) begin
            if (n_held_cnt == HELD_PCT || n_held_cnt == HELD_DIGIT) begin
                v_e = pcd_pkg::append(v_e, pcd_pkg::CH_PCT);
            end
            if (n_held_cnt == HELD_DIGIT) begin
                v_e = pcd_pkg::append(v_e, n_held_digit);
            end
            n_held_cnt = HELD_NONE;
        end
    end

    assign o_entry = v_e;
    assign o_push  = accept && (v_e.cnt != 2'd0);

    // Advance the held state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt   <= HELD_NONE;
            r_held_digit <= '0;
        end else if (accept) begin
            r_held_cnt   <= n_held_cnt;
            r_held_digit <= n_held_digit;
        end
    end

    `PCD_ASSERT(a_held_range, r_held_cnt != 2'd3)
    `PCD_ASSERT_MSG(a_last_clears, accept && i_data.in_last |=> r_held_cnt == HELD_NONE,
        "held bytes survived the last item")
    `PCD_ASSERT_MSG(a_digit_is_hex, r_held_cnt == HELD_DIGIT |-> v_hh.valid,
        "held digit is not hex")

endmodule

### rtl/pcd_queue.sv
`include "assert_macros.svh"

module pcd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pcd_pkg::t_entry  i_wr_data,
    input  logic             i_pop,
    output pcd_pkg::t_entry  o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    pcd_pkg::t_entry                 r_mem [pcd_pkg::QDEPTH];
    logic [pcd_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [pcd_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [pcd_pkg::QCNT_W-1:0]      r_count;

    assign o_full    = (r_count == pcd_pkg::QCNT_W'(pcd_pkg::QDEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `PCD_ASSERT_MSG(a_no_overflow, i_push |-> !o_full || i_pop, "queue overflow")
    `PCD_ASSERT_MSG(a_no_underflow, i_pop |-> !o_empty, "queue underflow")
    `PCD_ASSERT_MSG(a_push_nonempty, i_push |-> i_wr_data.cnt != 2'd0,
        "empty entry pushed")

endmodule

### rtl/pcd_back.sv
`include "assert_macros.svh"

module pcd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pcd_pkg::t_entry  i_q_data,
    input  logic             i_q_empty,
    output logic             o_pop,
    output logic             o_valid,
    output pcd_pkg::t_out    o_data,
    input  logic             i_stall
);

    pcd_pkg::t_entry r_cur;
    logic [1:0]      r_idx;
    logic            r_valid;
    logic            idx_last;
    logic            out_acc;
    logic [7:0]      cur_byte;

    assign idx_last = (r_idx == r_cur.cnt - 2'd1);
    assign out_acc  = r_valid && !i_stall;
    assign o_pop    = !i_q_empty && (!r_valid || (out_acc && idx_last));

    // Select the byte at the current slot
    always_comb begin
        case (r_idx)
            2'd0:    cur_byte = r_cur.bytes[0];
            2'd1:    cur_byte = r_cur.bytes[1];
            default: cur_byte = r_cur.bytes[2];
        endcase
    end

    assign o_valid         = r_valid;
    assign o_data.out_byte = cur_byte;
    assign o_data.out_last = r_cur.last && idx_last;

    // Load the next entry or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (out_acc) begin
            if (idx_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_data;
        end
    end

    `PCD_ASSERT_MSG(a_idx_range, r_valid |-> r_idx < r_cur.cnt, "slot index past entry")
    `PCD_ASSERT_MSG(a_hold_on_stall, r_valid && i_stall |=> r_valid && $stable(r_idx),
        "output moved while stalled")

endmodule

### rtl/percent_decoder.sv
// URL percent decoder, one encoded byte per input item.
// Input channel: i_valid / o_stall carry i_data (data_byte, in_last); an item
// is taken at a clock edge with i_valid high and o_stall low. Each item gives
// zero to three decoded bytes on o_valid / i_stall as o_data (out_byte,
// out_last); out_last marks the final byte produced for an item with in_last.
// A '%' and two hex digits decode to one byte; '+' becomes a space when the
// plus_as_space register (APB address 0, bit 0) is set.
// A byte passes through the queue and the serializer's entry register before
// it leaves. Throughput while i_stall is low: one item per cycle while each
// item yields at most one byte; the output serializer emits one byte per cycle,
// so an item that flushes a broken escape occupies it until all its bytes have
// left, and a four-entry queue between classifier and serializer absorbs the
// difference. Reset (synchronous, active low) drops held escape bytes,
// empties the queue and clears plus_as_space. While i_stall is high the current
// output byte is held; once the queue fills, o_stall rises and input items wait.
module percent_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pcd_pkg::t_in    i_data,
    output logic            o_stall,
    output logic            o_valid,
    output pcd_pkg::t_out   o_data,
    input  logic            i_stall,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic            r_plus_as_space;
    logic            cfg_wr;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    pcd_pkg::t_entry q_wr_data;
    pcd_pkg::t_entry q_rd_data;

    // Configuration register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_as_space <= 1'b0;
        end else if (cfg_wr && paddr[2] == pcd_pkg::REG_PLUS_AS_SPACE) begin
            r_plus_as_space <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == pcd_pkg::REG_PLUS_AS_SPACE) ?
                    {31'd0, r_plus_as_space} : 32'd0;

    pcd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_data          (i_data),
        .i_plus_as_space (r_plus_as_space),
        .i_q_full        (q_full),
        .o_stall         (o_stall),
        .o_push          (q_push),
        .o_entry         (q_wr_data)
    );

    pcd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_wr_data (q_wr_data),
        .i_pop     (q_pop),
        .o_rd_data (q_rd_data),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    pcd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_rd_data),
        .i_q_empty (q_empty),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

### bench/percent_decoder_tb.sv
`timescale 1ns / 1ps

module percent_decoder_tb;

    // What the decoder holds between input bytes
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_PCT,
        HOLD_DIGIT
    } t_hold;

    localparam logic [2:0] ADDR_PLUS   = {pcd_pkg::REG_PLUS_AS_SPACE, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = 3'd4;
    localparam string      HEX_CHARS   = "0123456789abcdefABCDEF";

    // Return {is_hex, digit value} for one character
    function automatic logic [4:0] hex_of(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            return {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            return {1'b1, 4'(c - 8'h57)};
        end
        return 5'b0;
    endfunction

    class decode_scoreboard;
        t_hold          hold;
        logic [7:0]     held_ch;
        bit             plus_sp;
        pcd_pkg::t_out  decoded_q[$];
        int             errors;

        function new();
            hold    = HOLD_NONE;
            held_ch = 8'h00;
            plus_sp = 1'b0;
            errors  = 0;
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        function void emit(logic [7:0] b);
            pcd_pkg::t_out o;
            o.out_byte = b;
            o.out_last = 1'b0;
            decoded_q.insert(decoded_q.size(), o);
        endfunction

        // Handle a byte as if nothing were held
        function void take_fresh(logic [7:0] b);
            if (b == pcd_pkg::CH_PCT) begin
                hold = HOLD_PCT;
            end else if (b == pcd_pkg::CH_PLUS && plus_sp) begin
                emit(pcd_pkg::CH_SPACE);
            end else begin
                emit(b);
            end
        endfunction

        // Work out the decoded bytes that one accepted item causes
        function void note_input(pcd_pkg::t_in it);
            int         base;
            logic [4:0] cur;
            logic [4:0] hi;
            base = decoded_q.size();
            cur  = hex_of(it.data_byte);
            case (hold)
                HOLD_PCT: begin
                    if (cur[4]) begin
                        held_ch = it.data_byte;
                        hold    = HOLD_DIGIT;
                    end else begin
                        hold = HOLD_NONE;
                        emit(pcd_pkg::CH_PCT);
                        take_fresh(it.data_byte);
                    end
                end
                HOLD_DIGIT: begin
                    hold = HOLD_NONE;
                    if (cur[4]) begin
                        hi = hex_of(held_ch);
                        emit({hi[3:0], cur[3:0]});
                    end else begin
                        emit(pcd_pkg::CH_PCT);
                        emit(held_ch);
                        take_fresh(it.data_byte);
                    end
                end
                default: begin
                    hold = HOLD_NONE;
                    take_fresh(it.data_byte);
                end
            endcase
            // Flush whatever is still held at the end of a string
            if (it.in_last) begin
                if (hold != HOLD_NONE) emit(pcd_pkg::CH_PCT);
                if (hold == HOLD_DIGIT) emit(held_ch);
                hold = HOLD_NONE;
                if (decoded_q.size() > base) decoded_q[decoded_q.size() - 1].out_last = 1'b1;
            end
        endfunction

        // Compare one output item with the oldest decoded byte waiting
        task check_result(pcd_pkg::t_out got);
            pcd_pkg::t_out want;
            if (decoded_q.size() == 0) begin
                report($sformatf("unexpected byte %h last %b", got.out_byte, got.out_last));
            end else begin
                want = decoded_q.pop_front();
                if (got.out_byte !== want.out_byte)
                    report($sformatf("out_byte got %h want %h", got.out_byte, want.out_byte));
                if (got.out_last !== want.out_last)
                    report($sformatf("out_last got %b want %b on byte %h",
                                     got.out_last, want.out_last, want.out_byte));
            end
        endtask
    endclass

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    pcd_pkg::t_in  i_data  = '0;
    logic          o_stall;
    logic          o_valid;
    pcd_pkg::t_out o_data;
    logic          i_stall = 1'b0;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [2:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;

    decode_scoreboard sb;
    bit               calm = 1'b0;
    int               stall_left = 0;

    percent_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short idle runs, a few long ones, none while calm
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Stall the output side in random runs
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            i_stall    <= !calm && ($urandom_range(0, 2) == 0);
            stall_left <= pick_len();
        end
    end

    // Check every output item taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    task apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task apb_check(logic [2:0] addr, logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) sb.report($sformatf("prdata got %h want %h", prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Present one item after a random gap and hold it until taken
    task send_item(pcd_pkg::t_in it);
        int gap;
        gap = pick_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(it);
    endtask

    task send_byte(logic [7:0] b, bit last);
        pcd_pkg::t_in it;
        it.data_byte = b;
        it.in_last   = last;
        send_item(it);
    endtask

    task send_text(string s, bit last_at_end);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], last_at_end && i == s.len() - 1);
    endtask

    function automatic logic [7:0] any_hex();
        return HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)];
    endfunction

    function automatic logic [7:0] any_nonhex();
        logic [7:0] b;
        logic [4:0] h;
        b = 8'($urandom_range(0, 255));
        h = hex_of(b);
        if (h[4]) b = b ^ 8'h40;
        return b;
    endfunction

    // Mostly well-formed escapes and text, with broken escapes and raw bytes mixed in
    task send_random(int count);
        int sent;
        int kind;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                send_byte(8'($urandom_range(8'h20, 8'h7E)), $urandom_range(0, 9) == 0);
                sent += 1;
            end else if (kind < 60) begin
                send_byte(pcd_pkg::CH_PCT, $urandom_range(0, 19) == 0);
                send_byte(any_hex(), $urandom_range(0, 19) == 0);
                send_byte(any_hex(), $urandom_range(0, 5) == 0);
                sent += 3;
            end else if (kind < 70) begin
                send_byte(pcd_pkg::CH_PLUS, $urandom_range(0, 9) == 0);
                sent += 1;
            end else if (kind < 82) begin
                send_byte(pcd_pkg::CH_PCT, 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    send_byte(any_hex(), 1'b0);
                    sent += 1;
                end
                send_byte(any_nonhex(), $urandom_range(0, 5) == 0);
                sent += 2;
            end else begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                sent += 1;
            end
        end
    endtask

    // Drop valid, drain every pending byte, then allow for bytes still in flight
    task wait_idle();
        i_valid <= 1'b0;
        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        bit plus_seq[4];
        plus_seq = '{1'b0, 1'b1, 1'b0, 1'b1};
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            calm = (ph == 2);
            apb_write(ADDR_PLUS, {31'b0, plus_seq[ph]});
            sb.plus_sp = plus_seq[ph];
            // A write past the last register must leave plus_as_space alone
            if (ph == 2) apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
            apb_check(ADDR_PLUS, {31'b0, plus_seq[ph]});

            if (ph == 0) begin
                // Both cases, extreme values, broken escapes, flush at the end
                send_text("%41%6f%fF%00+%G%4", 1'b1);
                send_byte(pcd_pkg::CH_PCT, 1'b0);
                send_byte(8'hC1, 1'b0);
                send_text("%%3", 1'b0);
                send_byte(8'hFF, 1'b1);
            end else if (ph == 1) begin
                // Plus after a held escape decodes fresh as a space
                send_text("%+%2+", 1'b0);
                send_byte(pcd_pkg::CH_PCT, 1'b1);
            end
            send_random(40);
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/pcd_pkg.sv
rtl/pcd_front.sv
rtl/pcd_queue.sv
rtl/pcd_back.sv
rtl/percent_decoder.sv
bench/percent_decoder_tb.sv
